// ----- design/gffr_pkg.sv -----
// ----------------------------------------------------------------------------
// gffr_pkg: shared types and codes of the grid first-fit allocator
// Request and result payloads, operation codes and register indexes.
// ----------------------------------------------------------------------------
package gffr_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 4'd1;

    // operation codes
    localparam logic [1:0] MODE_PLACE = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_PROBE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] rect_w;
        logic [4:0] rect_h;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] found_x;
        logic [3:0] found_y;
    } result_t;

endpackage

// ----- design/grid_first_fit_rect_allocator.sv -----
// ----------------------------------------------------------------------------
// grid_first_fit_rect_allocator: first-fit 2d rectangle allocator
// Occupancy bitmap with place, free and probe commands run by a sequencer.
// ----------------------------------------------------------------------------
// Usage: a command on req is taken at a clock edge with start high and busy
// low. busy stays high while the sequencer works. The answer appears on result
// for exactly one cycle with done high; the receiver cannot stall, so it must
// take every transfer as it comes. The next command may be started in the
// cycle done is high.
// Config: grid_width and grid_height are written over cfg_valid/cfg_ready
// (always ready) by the user only while the block is idle; the block does
// not itself enforce it. Indexes other than 0 and 1 are ignored.
// Sequence, set by the single registered read port of the column store:
//   probe reads one column if in range, else answers from idle; free reads
//   and writes back each column touched; place, per candidate column x, ORs
//   the columns under it, tests one candidate row per cycle, leaves the column
//   in a last scan step, then marks each column by read and write; on a 16
//   by 16 grid the worst case is a 1 by 1 place with only the last cell free.
// Reset: the grid reverts to 16 by 16 and every cell reads free at once.
// ----------------------------------------------------------------------------
module grid_first_fit_rect_allocator #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gffr_pkg::req_t                   req,
    output logic                             done,
    output gffr_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gffr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gffr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CAW = $clog2(MAX_COLS);
    localparam int XCW = $clog2(MAX_COLS + 1);
    localparam int YCW = $clog2(MAX_ROWS + 1);
    localparam int SW  = ((XCW > 5) ? XCW : 5) + 1;
    localparam int HW  = ((YCW > 5) ? YCW : 5) + 1;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_GATHER  = 6'b000010,
        S_SCAN    = 6'b000100,
        S_MARK_RD = 6'b001000,
        S_MARK_WR = 6'b010000,
        S_PROBE   = 6'b100000
    } state_t;

    // rows lo..hi-1
    function automatic logic [MAX_ROWS-1:0] range_mask(input logic [HW-1:0] lo,
                                                       input logic [HW-1:0] hi);
        logic [MAX_ROWS-1:0] m;
        m = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            m[r] = (HW'(r) >= lo) && (HW'(r) < hi);
        end
        return m;
    endfunction

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    gffr_pkg::result_t   result_reg, result_next;
    logic [4:0]          grid_width_reg, grid_height_reg;

    logic [SW-1:0]       x_reg, x_next;
    logic [SW-1:0]       col_reg, col_next;
    logic [SW-1:0]       x_end_reg, x_end_next;
    logic [HW-1:0]       y_reg, y_next;
    logic [HW-1:0]       rh_reg, rh_next;
    logic [MAX_ROWS-1:0] mask_reg, mask_next;
    logic [MAX_ROWS-1:0] acc_reg, acc_next;
    logic                pend_reg, pend_next;
    logic                clear_reg, clear_next;

    logic                rd_en;
    logic [CAW-1:0]      rd_addr;
    logic [MAX_ROWS-1:0] rd_data;
    logic                wr_en;
    logic [CAW-1:0]      wr_addr;
    logic [MAX_ROWS-1:0] wr_data;

    logic [SW-1:0]       cols_act;
    logic [HW-1:0]       rows_act;
    logic [SW-1:0]       rw_s, px_s, xe_sum, xe;
    logic [HW-1:0]       rh_h, py_h, ye_sum, ye;

    gffr_bitmap #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // active size saturates at the array size
    assign cols_act = (SW'(grid_width_reg) > SW'(MAX_COLS)) ? SW'(MAX_COLS)
                                                            : SW'(grid_width_reg);
    assign rows_act = (HW'(grid_height_reg) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS)
                                                             : HW'(grid_height_reg);

    assign rw_s   = SW'(req.rect_w);
    assign px_s   = SW'(req.pos_x);
    assign rh_h   = HW'(req.rect_h);
    assign py_h   = HW'(req.pos_y);
    assign xe_sum = px_s + rw_s;
    assign ye_sum = py_h + rh_h;
    assign xe     = (xe_sum > cols_act) ? cols_act : xe_sum;
    assign ye     = (ye_sum > rows_act) ? rows_act : ye_sum;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        x_next      = x_reg;
        col_next    = col_reg;
        x_end_next  = x_end_reg;
        y_next      = y_reg;
        rh_next     = rh_reg;
        mask_next   = mask_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        clear_next  = clear_reg;
        rd_en       = 1'b0;
        rd_addr     = col_reg[CAW-1:0];
        wr_en       = 1'b0;
        wr_addr     = col_reg[CAW-1:0];
        wr_data     = clear_reg ? (rd_data & ~mask_reg) : (rd_data | mask_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req.mode)
                        gffr_pkg::MODE_PLACE:
                        begin
                            if ((req.rect_w != 5'd0) && (req.rect_h != 5'd0) &&
                                (rw_s <= cols_act) && (rh_h <= rows_act))
                            begin
                                x_next     = '0;
                                col_next   = '0;
                                x_end_next = rw_s;
                                y_next     = '0;
                                rh_next    = rh_h;
                                mask_next  = range_mask('0, rh_h);
                                acc_next   = '0;
                                pend_next  = 1'b0;
                                clear_next = 1'b0;
                                state_next = S_GATHER;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{ok: 1'b0, found_x: 4'd0, found_y: 4'd0};
                            end
                        end
                        gffr_pkg::MODE_FREE:
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            col_next   = px_s;
                            x_end_next = xe;
                            mask_next  = range_mask(py_h, ye);
                            clear_next = 1'b1;
                            if (px_s < xe)
                            begin
                                state_next = S_MARK_RD;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{ok: 1'b1, found_x: 4'd0, found_y: 4'd0};
                            end
                        end
                        gffr_pkg::MODE_PROBE:
                        begin
                            if ((px_s < cols_act) && (py_h < rows_act))
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = px_s[CAW-1:0];
                                mask_next  = range_mask(py_h, py_h + HW'(1));
                                state_next = S_PROBE;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{ok: 1'b0, found_x: 4'd0, found_y: 4'd0};
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{ok: 1'b0, found_x: 4'd0, found_y: 4'd0};
                        end
                    endcase
                end
            end

            // OR together the columns under the candidate corner
            S_GATHER:
            begin
                if (col_reg != x_end_reg)
                begin
                    rd_en    = 1'b1;
                    col_next = col_reg + SW'(1);
                end
                pend_next = (col_reg != x_end_reg);
                if (pend_reg)
                begin
                    acc_next = acc_reg | rd_data;
                    if (col_reg == x_end_reg)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // one candidate row per cycle against the merged column word
            S_SCAN:
            begin
                if ((y_reg + rh_reg) > rows_act)
                begin
                    if (x_end_reg >= cols_act)
                    begin
                        done_next   = 1'b1;
                        result_next = '{ok: 1'b0, found_x: 4'd0, found_y: 4'd0};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        x_next     = x_reg + SW'(1);
                        col_next   = x_reg + SW'(1);
                        x_end_next = x_end_reg + SW'(1);
                        y_next     = '0;
                        mask_next  = range_mask('0, rh_reg);
                        acc_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_GATHER;
                    end
                end
                else if ((acc_reg & mask_reg) == '0)
                begin
                    col_next   = x_reg;
                    state_next = S_MARK_RD;
                end
                else
                begin
                    y_next    = y_reg + HW'(1);
                    mask_next = mask_reg << 1;
                end
            end

            S_MARK_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_MARK_WR;
            end

            // read-modify-write of one column
            S_MARK_WR:
            begin
                wr_en    = 1'b1;
                col_next = col_reg + SW'(1);
                if ((col_reg + SW'(1)) == x_end_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{ok: 1'b1, found_x: x_reg[3:0], found_y: y_reg[3:0]};
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_MARK_RD;
                end
            end

            S_PROBE:
            begin
                done_next   = 1'b1;
                result_next = '{ok: ((rd_data & mask_reg) == '0),
                                found_x: 4'd0, found_y: 4'd0};
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            grid_width_reg  <= 5'd16;
            grid_height_reg <= 5'd16;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gffr_pkg::REG_GRID_WIDTH)
                begin
                    grid_width_reg <= cfg_data;
                end
                else if (cfg_index == gffr_pkg::REG_GRID_HEIGHT)
                begin
                    grid_height_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        x_reg      <= x_next;
        col_reg    <= col_next;
        x_end_reg  <= x_end_next;
        y_reg      <= y_next;
        rh_reg     <= rh_next;
        mask_reg   <= mask_next;
        acc_reg    <= acc_next;
        clear_reg  <= clear_next;
    end

endmodule

// ----- design/gffr_bitmap.sv -----
// ----------------------------------------------------------------------------
// gffr_bitmap: occupancy column store
// One word per column, one bit per row. Registered read, one write port.
// Per-column valid flags make every column read as all-free after reset.
// ----------------------------------------------------------------------------
module gffr_bitmap #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
    output logic [MAX_ROWS-1:0]         rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_COLS)-1:0] wr_addr,
    input  logic [MAX_ROWS-1:0]         wr_data
);

    logic [MAX_ROWS-1:0] mem [MAX_COLS];
    logic [MAX_COLS-1:0] col_valid_reg;
    logic [MAX_ROWS-1:0] rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                col_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= col_valid_reg[rd_addr];
            end
        end
    end

    // a column never written since reset is all free
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: grid first-fit rectangle allocator
// Directed and random place, free and probe commands over several grid sizes.
// Answers are predicted from a private copy of the occupancy bitmap and
// compared field by field as each done strobe arrives.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         GRID_COLS    = 16;
    localparam int         GRID_ROWS    = 16;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = 600;
    localparam int         IDX_W        = gffr_pkg::CFG_INDEX_W;
    localparam int         DAT_W        = gffr_pkg::CFG_DATA_W;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic             is_reg;
        logic [IDX_W-1:0] reg_index;
        logic [DAT_W-1:0] reg_value;
        gffr_pkg::req_t   cmd;
    } grid_job_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    gffr_pkg::req_t    req       = '0;
    logic              done;
    gffr_pkg::result_t result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DAT_W-1:0]  cfg_data  = '0;

    // private copy of the grid state
    logic [GRID_ROWS-1:0] occ_cols [GRID_COLS] = '{default: '0};
    logic [DAT_W-1:0]     grid_w = 5'd16;
    logic [DAT_W-1:0]     grid_h = 5'd16;

    grid_job_t         job_backlog[$];
    gffr_pkg::result_t expected_answers[$];

    int cmds_accepted  = 0;
    int reg_writes     = 0;
    int answers_checked = 0;
    int places_granted = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int burst_left     = 1;
    int pause_left     = 0;

    grid_first_fit_rect_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // applies one command to the grid copy and returns the answer it gives
    function automatic gffr_pkg::result_t grid_answer(gffr_pkg::req_t cmd);
        gffr_pkg::result_t    ans;
        int                   cols;
        int                   rows;
        int                   x;
        int                   y;
        int                   c;
        int                   x_end;
        int                   y_end;
        logic [GRID_ROWS-1:0] span;
        logic                 fits;
        ans  = '0;
        cols = (grid_w > GRID_COLS) ? GRID_COLS : int'(grid_w);
        rows = (grid_h > GRID_ROWS) ? GRID_ROWS : int'(grid_h);
        case (cmd.mode)
            gffr_pkg::MODE_PLACE:
            begin
                if (cmd.rect_w != 0 && cmd.rect_h != 0 && cmd.rect_w <= cols
                    && cmd.rect_h <= rows)
                begin
                    for (x = 0; x + int'(cmd.rect_w) <= cols && !ans.ok; x++)
                    begin
                        for (y = 0; y + int'(cmd.rect_h) <= rows && !ans.ok; y++)
                        begin
                            span = '0;
                            for (c = y; c < y + int'(cmd.rect_h); c++)
                                span[c] = 1'b1;
                            fits = 1'b1;
                            for (c = x; c < x + int'(cmd.rect_w); c++)
                                if ((occ_cols[c] & span) != '0)
                                    fits = 1'b0;
                            if (fits)
                            begin
                                for (c = x; c < x + int'(cmd.rect_w); c++)
                                    occ_cols[c] |= span;
                                ans.ok      = 1'b1;
                                ans.found_x = 4'(x);
                                ans.found_y = 4'(y);
                            end
                        end
                    end
                end
            end
            gffr_pkg::MODE_FREE:
            begin
                // cells beyond the active grid stay as they are
                x_end = int'(cmd.pos_x) + int'(cmd.rect_w);
                y_end = int'(cmd.pos_y) + int'(cmd.rect_h);
                if (x_end > cols)
                    x_end = cols;
                if (y_end > rows)
                    y_end = rows;
                span = '0;
                for (c = int'(cmd.pos_y); c < y_end; c++)
                    span[c] = 1'b1;
                for (c = int'(cmd.pos_x); c < x_end; c++)
                    occ_cols[c] &= ~span;
                ans.ok = 1'b1;
            end
            gffr_pkg::MODE_PROBE:
            begin
                if (cmd.pos_x < cols && cmd.pos_y < rows && !occ_cols[cmd.pos_x][cmd.pos_y])
                    ans.ok = 1'b1;
            end
            default:
            begin
                ans = '0;
            end
        endcase
        return ans;
    endfunction

    task automatic queue_cmd(input logic [1:0] mode, input int w, input int h,
                             input int x, input int y);
        grid_job_t job;
        job             = '0;
        job.cmd.mode    = mode;
        job.cmd.rect_w  = 5'(w);
        job.cmd.rect_h  = 5'(h);
        job.cmd.pos_x   = 4'(x);
        job.cmd.pos_y   = 4'(y);
        job_backlog.push_back(job);
    endtask

    task automatic queue_reg(input logic [IDX_W-1:0] index, input int value);
        grid_job_t job;
        job           = '0;
        job.is_reg    = 1'b1;
        job.reg_index = index;
        job.reg_value = 5'(value);
        job_backlog.push_back(job);
    endtask

    // sender: bursts of commands with random pauses, register writes only when idle
    always @(posedge clk)
    begin : driver
        grid_job_t head;
        logic      launched;
        logic      written;
        logic      hold_start;
        logic      hold_cfg;
        launched = start && !busy;
        written  = cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (launched)
            begin
                gffr_pkg::result_t ans;
                ans = grid_answer(req);
                expected_answers.push_back(ans);
                cmds_accepted++;
                if (req.mode == gffr_pkg::MODE_PLACE && ans.ok)
                    places_granted++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    pause_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    burst_left = $urandom_range(1, 24);
                end
            end
            if (written)
            begin
                reg_writes++;
                if (cfg_index == gffr_pkg::REG_GRID_WIDTH)
                    grid_w = cfg_data;
                else if (cfg_index == gffr_pkg::REG_GRID_HEIGHT)
                    grid_h = cfg_data;
            end
            hold_start = start && !launched;
            hold_cfg   = cfg_valid && !written;
            if (!hold_start && !hold_cfg && job_backlog.size() != 0)
            begin
                head = job_backlog[0];
                if (head.is_reg)
                begin
                    // a done this edge may not be popped yet, so wait while done is high
                    if (!launched && !busy && !done && expected_answers.size() == 0)
                    begin
                        void'(job_backlog.pop_front());
                        hold_cfg = 1'b1;
                        cfg_index <= head.reg_index;
                        cfg_data  <= head.reg_value;
                    end
                end
                else if (pause_left > 0)
                begin
                    pause_left--;
                end
                else
                begin
                    void'(job_backlog.pop_front());
                    hold_start = 1'b1;
                    req <= head.cmd;
                end
            end
            start     <= hold_start;
            cfg_valid <= hold_cfg;
        end
    end

    always @(posedge clk)
    begin : monitor
        gffr_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: answer with no command pending: ok=%0d x=%0d y=%0d",
                         $time, result.ok, result.found_x, result.found_y);
                mismatches++;
            end
            else
            begin
                want = expected_answers.pop_front();
                answers_checked++;
                if (result.ok !== want.ok)
                begin
                    $display("%0t: ok expected %0d got %0d", $time, want.ok, result.ok);
                    mismatches++;
                end
                if (result.found_x !== want.found_x)
                begin
                    $display("%0t: found_x expected %0d got %0d",
                             $time, want.found_x, result.found_x);
                    mismatches++;
                end
                if (result.found_y !== want.found_y)
                begin
                    $display("%0t: found_y expected %0d got %0d",
                             $time, want.found_y, result.found_y);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        int i;
        int pick;
        int w;
        int h;
        // directed, 16 by 16 grid after reset
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 0, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 16, 16, 0, 0);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 15, 15);
        queue_cmd(gffr_pkg::MODE_PLACE, 1, 1, 0, 0);
        queue_cmd(gffr_pkg::MODE_FREE, 31, 31, 0, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 0, 5, 0, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 5, 0, 0, 0);
        queue_cmd(gffr_pkg::MODE_FREE, 0, 0, 3, 3);
        queue_cmd(gffr_pkg::MODE_PLACE, 3, 2, 0, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 2, 5, 0, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 4, 16, 0, 0);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 1, 1);
        queue_cmd(gffr_pkg::MODE_PROBE, 31, 31, 7, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 17, 1, 0, 0);
        queue_cmd(gffr_pkg::MODE_FREE, 5, 5, 14, 14);
        queue_cmd(MODE_UNUSED, 31, 31, 15, 15);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 15, 0);
        queue_cmd(gffr_pkg::MODE_FREE, 16, 16, 0, 0);
        // empty grid, then oversized registers that saturate
        queue_reg(gffr_pkg::REG_GRID_WIDTH, 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 1, 1, 0, 0);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 0, 15);
        queue_reg(gffr_pkg::REG_GRID_WIDTH, 31);
        queue_reg(gffr_pkg::REG_GRID_HEIGHT, 31);
        queue_reg(IDX_W'((1 << IDX_W) - 1), 0);
        queue_cmd(gffr_pkg::MODE_PLACE, 16, 16, 0, 0);
        // shrink: the free below only reaches the one visible cell
        queue_reg(gffr_pkg::REG_GRID_WIDTH, 1);
        queue_reg(gffr_pkg::REG_GRID_HEIGHT, 1);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 0, 0);
        queue_cmd(gffr_pkg::MODE_FREE, 16, 16, 0, 0);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 0, 0);
        queue_reg(gffr_pkg::REG_GRID_WIDTH, 16);
        queue_reg(gffr_pkg::REG_GRID_HEIGHT, 16);
        queue_cmd(gffr_pkg::MODE_PROBE, 0, 0, 5, 5);
        queue_cmd(gffr_pkg::MODE_FREE, 31, 31, 0, 0);

        // random phases, each under its own grid size
        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:
                begin
                    w = 16;
                    h = 16;
                end
                1:
                begin
                    w = 1;
                    h = 16;
                end
                2:
                begin
                    w = 16;
                    h = 1;
                end
                3:
                begin
                    w = 0;
                    h = $urandom_range(0, 31);
                end
                4:
                begin
                    w = 31;
                    h = 31;
                end
                default:
                begin
                    w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(2, 16);
                    h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(2, 16);
                end
            endcase
            queue_reg(gffr_pkg::REG_GRID_WIDTH, w);
            queue_reg(gffr_pkg::REG_GRID_HEIGHT, h);
            if ($urandom_range(0, 2) == 0)
                queue_reg(IDX_W'($urandom_range(int'(gffr_pkg::REG_GRID_HEIGHT) + 1,
                                                (1 << IDX_W) - 1)),
                          $urandom_range(0, 31));
            n = (w == 0 || h == 0) ? 20 : 90;
            for (i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    if ($urandom_range(0, 9) == 0)
                        queue_cmd(gffr_pkg::MODE_PLACE, $urandom_range(0, 31),
                                  $urandom_range(0, 31),
                                  $urandom_range(0, 15), $urandom_range(0, 15));
                    else
                        queue_cmd(gffr_pkg::MODE_PLACE, $urandom_range(1, 4),
                                  $urandom_range(1, 4),
                                  $urandom_range(0, 15), $urandom_range(0, 15));
                end
                else if (pick < 65)
                begin
                    if ($urandom_range(0, 19) == 0)
                        queue_cmd(gffr_pkg::MODE_FREE, 31, 31, 0, 0);
                    else if ($urandom_range(0, 9) == 0)
                        queue_cmd(gffr_pkg::MODE_FREE, $urandom_range(0, 31),
                                  $urandom_range(0, 31),
                                  $urandom_range(0, 15), $urandom_range(0, 15));
                    else
                        queue_cmd(gffr_pkg::MODE_FREE, $urandom_range(1, 5),
                                  $urandom_range(1, 5),
                                  $urandom_range(0, 15), $urandom_range(0, 15));
                end
                else if (pick < 95)
                begin
                    queue_cmd(gffr_pkg::MODE_PROBE, $urandom_range(0, 31),
                              $urandom_range(0, 31),
                              $urandom_range(0, 15), $urandom_range(0, 15));
                end
                else
                begin
                    queue_cmd(MODE_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 15), $urandom_range(0, 15));
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (job_backlog.size() != 0 || start || cfg_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d answers to %0d commands, %0d placements granted",
                 answers_checked, cmds_accepted, places_granted);
        $display("%0d register writes across 10 random grid sizes plus directed cases",
                 reg_writes);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
design/gffr_pkg.sv
design/gffr_bitmap.sv
design/grid_first_fit_rect_allocator.sv
tb/testbench.sv
